// ===== hdl/wrt_pkg.sv =====
// ---------------------------------------------------------------------------
// wrt_pkg: shared types and constants for the watchpoint range table
// Entry layout, request word layout, per-cell control and the op codes.
// ---------------------------------------------------------------------------
package wrt_pkg;

  localparam int DEPTH      = 8;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int IN_INDEX_W = 4;
  localparam int CMP_W      = (CNT_W > IN_INDEX_W) ? CNT_W : IN_INDEX_W;
  localparam int ADDR_W     = 22;
  localparam int LEN_W      = 16;
  localparam int LADDR_W    = 16;
  localparam int OUT_HIT_W  = 4;
  localparam int OUT_CNT_W  = 4;
  localparam int MODE_W     = 3;
  localparam int S_TDATA_W  = 88;
  localparam int M_TDATA_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_SET_EN = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_FIND   = 3'd4,
    MODE_CHECK  = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  length;
    logic              phys;
    logic              en;
    logic              rd;
    logic              wr;
  } entry_t;

  typedef struct packed {
    mode_t                 mode;
    logic [ADDR_W-1:0]     address;
    logic [LEN_W-1:0]      length;
    logic                  is_physical;
    logic                  on_read;
    logic                  on_write;
    logic [IN_INDEX_W-1:0] index;
    logic                  enable_value;
    logic [LADDR_W-1:0]    logical_address;
    logic [ADDR_W-1:0]     physical_address;
    logic                  is_read;
  } req_t;

  typedef struct packed {
    logic             eval;
    logic             add_go;
    logic             rem_go;
    logic             sen_go;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage

// ===== hdl/wrt_cell.sv =====
// ---------------------------------------------------------------------------
// wrt_cell: one watchpoint slot
// Holds one entry, takes its upper neighbor's entry on remove, and compares
// its entry against the current find or check request.
// ---------------------------------------------------------------------------
module wrt_cell (
  input  logic                     clk,
  input  wrt_pkg::cell_ctl_t       ctl,
  input  wrt_pkg::req_t            req,
  input  logic [wrt_pkg::IDX_W-1:0] cell_id,
  input  wrt_pkg::entry_t          next_entry,
  output wrt_pkg::entry_t          entry,
  output logic                     match,
  output logic                     live_en
);

  logic                        valid;
  logic                        add_here;
  logic                        shift_here;
  logic                        set_here;
  logic [wrt_pkg::ADDR_W-1:0]  acc;
  logic [wrt_pkg::ADDR_W-1:0]  diff;
  logic                        in_range;
  logic                        dir_ok;
  logic                        check_hit;
  logic                        find_hit;
  logic                        match_next;
  wrt_pkg::entry_t             new_entry;

  assign valid      = wrt_pkg::CNT_W'(cell_id) < ctl.count;
  assign add_here   = ctl.add_go && (wrt_pkg::CNT_W'(cell_id) == ctl.count);
  assign shift_here = ctl.rem_go && (cell_id >= ctl.idx);
  assign set_here   = ctl.sen_go && (cell_id == ctl.idx);
  assign live_en    = valid && entry.en;

  always_comb begin
    new_entry.start  = req.address;
    new_entry.length = req.length;
    new_entry.phys   = req.is_physical;
    new_entry.en     = 1'b1;
    new_entry.rd     = req.on_read;
    new_entry.wr     = req.on_write;
  end

  // half-open range test against the address of the entry's kind
  assign acc      = entry.phys ? req.physical_address
                               : wrt_pkg::ADDR_W'(req.logical_address);
  assign diff     = acc - entry.start;
  assign in_range = (acc >= entry.start) && (diff < wrt_pkg::ADDR_W'(entry.length));
  assign dir_ok   = req.is_read ? entry.rd : entry.wr;

  assign check_hit = valid && entry.en && dir_ok && in_range;
  assign find_hit  = valid && (entry.start == req.address) && (entry.phys == req.is_physical);

  always_comb begin
    case (req.mode)
      wrt_pkg::MODE_FIND:  match_next = find_hit;
      wrt_pkg::MODE_CHECK: match_next = check_hit;
      default:             match_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.eval) begin
      match <= match_next;
    end
    if (add_here) begin
      entry <= new_entry;
    end else if (shift_here) begin
      entry <= next_entry;
    end else if (set_here) begin
      entry.en <= req.enable_value;
    end
  end

endmodule

// ===== hdl/watchpoint_range_table.sv =====
// ---------------------------------------------------------------------------
// watchpoint_range_table: debug watchpoint table with range checking
// A row of cells holds the entries; a small sequencer applies one operation
// per word and resolves the lowest matching cell.
// ---------------------------------------------------------------------------
// an accepted word passes through the exec (cell update) and resolve (priority
//   resolve) states of the sequencer before its result word is loaded; the next
//   word is taken only after resolve, which waits while the output is still full
// a new word is taken while the previous result still waits on m_tready
// reset (rst, synchronous): count and active cleared, result empty;
//   entry contents are left as they are and never read before written
module watchpoint_range_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // address[21:0], length[37:22], is_physical[38], on_read[39], on_write[40],
  // index[44:41], enable_value[45], logical_address[61:46],
  // physical_address[83:62], is_read[84], zero fill above
  input  logic [wrt_pkg::S_TDATA_W-1:0] s_tdata,
  // mode[2:0]
  input  logic [wrt_pkg::MODE_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // ok[0], hit_index[4:1], entry_count[8:5], any_active[9], zero fill above
  output logic [wrt_pkg::M_TDATA_W-1:0] m_tdata
);

  wrt_pkg::state_t             state;
  wrt_pkg::state_t             state_next;
  wrt_pkg::req_t               req;
  wrt_pkg::cell_ctl_t          ctl;
  logic [wrt_pkg::CNT_W-1:0]   count;
  logic [wrt_pkg::CNT_W-1:0]   count_next;
  logic                        active;
  logic                        active_next;
  logic                        op_ok;
  logic                        op_ok_next;
  logic                        recompute;
  logic                        recompute_next;
  logic                        in_accept;
  logic                        eval;
  logic                        res_load;
  logic                        idx_ok;
  logic                        add_ok;
  logic [wrt_pkg::DEPTH-1:0]   match;
  logic [wrt_pkg::DEPTH-1:0]   live_en;
  logic [wrt_pkg::IDX_W-1:0]   hit_idx;
  logic                        any_match;
  logic                        ok_res;
  logic [wrt_pkg::OUT_HIT_W-1:0] hit_res;
  logic                        active_res;
  wrt_pkg::entry_t             cell_entry [wrt_pkg::DEPTH];

  // ---------------- sequencer ----------------
  always_comb begin
    state_next = state;
    case (state)
      wrt_pkg::ST_IDLE:    if (s_tvalid) state_next = wrt_pkg::ST_EXEC;
      wrt_pkg::ST_EXEC:    state_next = wrt_pkg::ST_RESOLVE;
      wrt_pkg::ST_RESOLVE: if (!m_tvalid || m_tready) state_next = wrt_pkg::ST_IDLE;
      default:             state_next = wrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    eval     = 1'b0;
    res_load = 1'b0;
    case (state)
      wrt_pkg::ST_IDLE:    s_tready = 1'b1;
      wrt_pkg::ST_EXEC:    eval = 1'b1;
      wrt_pkg::ST_RESOLVE: res_load = !m_tvalid || m_tready;
      default:             s_tready = 1'b0;
    endcase
  end

  assign in_accept = s_tvalid && s_tready;

  // ---------------- operation decode ----------------
  assign idx_ok = wrt_pkg::CMP_W'(req.index) < wrt_pkg::CMP_W'(count);
  assign add_ok = (count < wrt_pkg::CNT_W'(wrt_pkg::DEPTH)) && (req.length != '0)
                  && (req.on_read || req.on_write);

  always_comb begin
    count_next     = count;
    active_next    = active;
    op_ok_next     = 1'b0;
    recompute_next = 1'b0;
    ctl.eval       = eval;
    ctl.add_go     = 1'b0;
    ctl.rem_go     = 1'b0;
    ctl.sen_go     = 1'b0;
    ctl.idx        = req.index[wrt_pkg::IDX_W-1:0];
    ctl.count      = count;
    case (req.mode)
      wrt_pkg::MODE_ADD: begin
        if (add_ok) begin
          ctl.add_go  = eval;
          count_next  = count + 1'b1;
          active_next = 1'b1;
          op_ok_next  = 1'b1;
        end
      end
      wrt_pkg::MODE_REMOVE: begin
        if (idx_ok) begin
          ctl.rem_go     = eval;
          count_next     = count - 1'b1;
          op_ok_next     = 1'b1;
          recompute_next = 1'b1;
        end
      end
      wrt_pkg::MODE_SET_EN: begin
        if (idx_ok) begin
          ctl.sen_go     = eval;
          op_ok_next     = 1'b1;
          recompute_next = 1'b1;
        end
      end
      wrt_pkg::MODE_CLEAR: begin
        count_next  = '0;
        active_next = 1'b0;
        op_ok_next  = 1'b1;
      end
      default: op_ok_next = 1'b0;
    endcase
  end

  // ---------------- cell row ----------------
  for (genvar g = 0; g < wrt_pkg::DEPTH; g++) begin : g_cell
    wrt_pkg::entry_t nb;
    if (g == wrt_pkg::DEPTH - 1) begin : g_top
      assign nb = '0;
    end else begin : g_mid
      assign nb = cell_entry[g+1];
    end
    wrt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .req        (req),
      .cell_id    (wrt_pkg::IDX_W'(g)),
      .next_entry (nb),
      .entry      (cell_entry[g]),
      .match      (match[g]),
      .live_en    (live_en[g])
    );
  end

  // ---------------- resolve ----------------
  always_comb begin
    hit_idx = '0;
    for (int i = wrt_pkg::DEPTH - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = wrt_pkg::IDX_W'(i);
    end
  end

  assign any_match  = |match;
  assign active_res = recompute ? (|live_en) : active;

  always_comb begin
    case (req.mode)
      wrt_pkg::MODE_FIND:  ok_res = any_match;
      wrt_pkg::MODE_CHECK: ok_res = active && any_match;
      default:             ok_res = op_ok;
    endcase
  end

  assign hit_res = ((req.mode inside {wrt_pkg::MODE_FIND, wrt_pkg::MODE_CHECK}) && ok_res)
                   ? wrt_pkg::OUT_HIT_W'(hit_idx) : '0;

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= wrt_pkg::ST_IDLE;
      count    <= '0;
      active   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (eval) begin
        count  <= count_next;
        active <= active_next;
      end else if (res_load && recompute) begin
        active <= active_res;
      end
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req.mode             <= wrt_pkg::mode_t'(s_tuser);
      req.address          <= s_tdata[21:0];
      req.length           <= s_tdata[37:22];
      req.is_physical      <= s_tdata[38];
      req.on_read          <= s_tdata[39];
      req.on_write         <= s_tdata[40];
      req.index            <= s_tdata[44:41];
      req.enable_value     <= s_tdata[45];
      req.logical_address  <= s_tdata[61:46];
      req.physical_address <= s_tdata[83:62];
      req.is_read          <= s_tdata[84];
    end
    if (eval) begin
      op_ok     <= op_ok_next;
      recompute <= recompute_next;
    end
    if (res_load) begin
      m_tdata <= {6'b0, active_res, wrt_pkg::OUT_CNT_W'(count), hit_res, ok_res};
    end
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the watchpoint range table
// Walks a short table of directed operations, then about 1350 random ones,
// through the stream ports with random gaps and back-pressure. Every result
// word is checked against the bench table model or a fixed directed expectation.
// ---------------------------------------------------------------------------
module tb;

  localparam int DEPTH      = wrt_pkg::DEPTH;
  localparam int MODE_W     = wrt_pkg::MODE_W;
  localparam int ADDR_W     = wrt_pkg::ADDR_W;
  localparam int LEN_W      = wrt_pkg::LEN_W;
  localparam int IN_INDEX_W = wrt_pkg::IN_INDEX_W;
  localparam int LADDR_W    = wrt_pkg::LADDR_W;
  localparam int OUT_HIT_W  = wrt_pkg::OUT_HIT_W;
  localparam int OUT_CNT_W  = wrt_pkg::OUT_CNT_W;
  localparam int S_TDATA_W  = wrt_pkg::S_TDATA_W;
  localparam int M_TDATA_W  = wrt_pkg::M_TDATA_W;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int N_RANDOM     = 1350;
  localparam int N_CALM       = 150;
  localparam int STALL_AT     = 300;
  localparam int LONG_STALL   = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int EXP_DEPTH    = 16;
  localparam int MAX_ROWS     = 64;

  typedef struct {
    logic [MODE_W-1:0]     mode;
    logic [ADDR_W-1:0]     address;
    logic [LEN_W-1:0]      length;
    logic                  phys;
    logic                  rd;
    logic                  wr;
    logic [IN_INDEX_W-1:0] index;
    logic                  env;
    logic [LADDR_W-1:0]    laddr;
    logic [ADDR_W-1:0]     paddr;
    logic                  is_read;
  } wp_req_t;

  typedef struct {
    logic                 ok;
    logic [OUT_HIT_W-1:0] hit;
    logic [OUT_CNT_W-1:0] cnt;
    logic                 act;
  } wp_result_t;

  typedef struct {
    wp_req_t    req;
    bit         fixed;
    wp_result_t exp;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [MODE_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;

  // bench copy of the table
  wrt_pkg::entry_t wp_tab [DEPTH];
  int              wp_count;
  bit              wp_active;

  // expected result words in order, as a ring
  wp_result_t exp_fifo [EXP_DEPTH];
  int         exp_wr;
  int         exp_rd;

  // directed stimulus table
  dir_row_t rows [MAX_ROWS];
  int       n_rows;

  int errors;
  int n_words;
  int n_results;
  int n_hits;
  int n_rejects;
  bit calm;
  bit stall_req;

  watchpoint_range_table i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #800000;
    $display("timeout with %0d results outstanding", exp_wr - exp_rd);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void refresh_active();
    int i;
    wp_active = 1'b0;
    for (i = 0; i < wp_count; i++) begin
      if (wp_tab[i].en) wp_active = 1'b1;
    end
  endfunction

  // applies one operation to the bench table and returns its result word
  function automatic wp_result_t watch_step(wp_req_t r);
    wp_result_t res;
    logic [ADDR_W-1:0] a;
    bit found;
    int i;
    res.ok  = 1'b0;
    res.hit = '0;
    found   = 1'b0;
    case (r.mode)
      wrt_pkg::MODE_ADD: begin
        if (wp_count < DEPTH && r.length != 0 && (r.rd || r.wr)) begin
          wp_tab[wp_count] = '{start: r.address, length: r.length, phys: r.phys,
                               en: 1'b1, rd: r.rd, wr: r.wr};
          wp_count++;
          wp_active = 1'b1;
          res.ok = 1'b1;
        end
      end
      wrt_pkg::MODE_REMOVE: begin
        if (r.index < wp_count) begin
          for (i = r.index; i + 1 < wp_count; i++) wp_tab[i] = wp_tab[i + 1];
          wp_count--;
          refresh_active();
          res.ok = 1'b1;
        end
      end
      wrt_pkg::MODE_SET_EN: begin
        if (r.index < wp_count) begin
          wp_tab[r.index].en = r.env;
          refresh_active();
          res.ok = 1'b1;
        end
      end
      wrt_pkg::MODE_CLEAR: begin
        wp_count  = 0;
        wp_active = 1'b0;
        res.ok    = 1'b1;
      end
      wrt_pkg::MODE_FIND: begin
        for (i = 0; i < wp_count; i++) begin
          if (!found && wp_tab[i].start == r.address && wp_tab[i].phys == r.phys) begin
            found   = 1'b1;
            res.ok  = 1'b1;
            res.hit = OUT_HIT_W'(i);
          end
        end
      end
      wrt_pkg::MODE_CHECK: begin
        if (wp_active) begin
          for (i = 0; i < wp_count; i++) begin
            a = wp_tab[i].phys ? r.paddr : ADDR_W'(r.laddr);
            if (!found && wp_tab[i].en && (r.is_read ? wp_tab[i].rd : wp_tab[i].wr) &&
                a >= wp_tab[i].start && (a - wp_tab[i].start) < wp_tab[i].length) begin
              found   = 1'b1;
              res.ok  = 1'b1;
              res.hit = OUT_HIT_W'(i);
            end
          end
        end
      end
      default: ;
    endcase
    res.cnt = wp_count[OUT_CNT_W-1:0];
    res.act = wp_active;
    return res;
  endfunction

  function automatic wp_req_t blank_req(logic [MODE_W-1:0] mode);
    wp_req_t r;
    r.mode    = mode;
    r.address = '0;
    r.length  = '0;
    r.phys    = 1'b0;
    r.rd      = 1'b0;
    r.wr      = 1'b0;
    r.index   = '0;
    r.env     = 1'b0;
    r.laddr   = '0;
    r.paddr   = '0;
    r.is_read = 1'b0;
    return r;
  endfunction

  function automatic wp_req_t w_add(logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                                    logic phys, logic rd, logic wr);
    wp_req_t r;
    r = blank_req(wrt_pkg::MODE_ADD);
    r.address = addr;
    r.length  = len;
    r.phys    = phys;
    r.rd      = rd;
    r.wr      = wr;
    return r;
  endfunction

  function automatic wp_req_t w_idx(logic [MODE_W-1:0] mode, logic [IN_INDEX_W-1:0] idx,
                                    logic env);
    wp_req_t r;
    r = blank_req(mode);
    r.index = idx;
    r.env   = env;
    return r;
  endfunction

  function automatic wp_req_t w_find(logic [ADDR_W-1:0] addr, logic phys);
    wp_req_t r;
    r = blank_req(wrt_pkg::MODE_FIND);
    r.address = addr;
    r.phys    = phys;
    return r;
  endfunction

  function automatic wp_req_t w_check(logic [LADDR_W-1:0] laddr, logic [ADDR_W-1:0] paddr,
                                      logic is_read);
    wp_req_t r;
    r = blank_req(wrt_pkg::MODE_CHECK);
    r.laddr   = laddr;
    r.paddr   = paddr;
    r.is_read = is_read;
    return r;
  endfunction

  function automatic dir_row_t pred_row(wp_req_t r);
    dir_row_t row;
    row.req   = r;
    row.fixed = 1'b0;
    row.exp   = '{ok: 1'b0, hit: '0, cnt: '0, act: 1'b0};
    return row;
  endfunction

  function automatic dir_row_t fixed_row(wp_req_t r, logic ok, int cnt, logic act);
    dir_row_t row;
    row.req   = r;
    row.fixed = 1'b1;
    row.exp   = '{ok: ok, hit: '0, cnt: OUT_CNT_W'(cnt), act: act};
    return row;
  endfunction

  function automatic void add_row(dir_row_t row);
    rows[n_rows] = row;
    n_rows++;
  endfunction

  // random operation shaped by the current table contents
  function automatic wp_req_t rand_req();
    wp_req_t r;
    wrt_pkg::entry_t e;
    logic [ADDR_W-1:0] a;
    int pick;
    int k;
    r.address = ADDR_W'($urandom);
    r.length  = LEN_W'($urandom);
    r.phys    = 1'($urandom);
    r.rd      = 1'($urandom);
    r.wr      = 1'($urandom);
    r.index   = IN_INDEX_W'($urandom);
    r.env     = 1'($urandom);
    r.laddr   = LADDR_W'($urandom);
    r.paddr   = ADDR_W'($urandom);
    r.is_read = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      r.mode = wrt_pkg::MODE_ADD;
      if ($urandom_range(0, 9) != 0) r.length = LEN_W'($urandom_range(1, 64));
      if ($urandom_range(0, 19) == 0) r.length = '0;
      if (!r.phys && $urandom_range(0, 3) != 0) r.address = ADDR_W'($urandom_range(0, 16'hFFFF));
      if (!r.rd && !r.wr && $urandom_range(0, 4) != 0) r.rd = 1'b1;
    end else if (pick < 46) begin
      r.mode = (pick < 34) ? wrt_pkg::MODE_REMOVE : wrt_pkg::MODE_SET_EN;
      if ($urandom_range(0, 7) != 0) r.index = IN_INDEX_W'($urandom_range(0, wp_count));
    end else if (pick < 50) begin
      r.mode = wrt_pkg::MODE_CLEAR;
    end else if (pick < 64) begin
      r.mode = wrt_pkg::MODE_FIND;
      if (wp_count > 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, wp_count - 1);
        r.address = wp_tab[k].start;
        r.phys    = wp_tab[k].phys ^ ($urandom_range(0, 4) == 0);
      end
    end else if (pick < 98) begin
      r.mode = wrt_pkg::MODE_CHECK;
      if (wp_count > 0 && $urandom_range(0, 5) != 0) begin
        e = wp_tab[$urandom_range(0, wp_count - 1)];
        // aim at the range edges most of the time
        case ($urandom_range(0, 4))
          0:       a = e.start - 1'b1;
          1:       a = e.start;
          2:       a = e.start + e.length - 1'b1;
          3:       a = e.start + e.length;
          default: a = e.start + ADDR_W'($urandom_range(0, e.length - 1));
        endcase
        if (e.phys) r.paddr = a;
        else r.laddr = a[LADDR_W-1:0];
        if ($urandom_range(0, 3) != 0) r.is_read = e.rd && !(e.wr && $urandom_range(0, 1));
      end
    end else begin
      r.mode = $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
    end
    return r;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_word(wp_req_t r);
    logic [S_TDATA_W-1:0] d;
    d        = '0;
    d[21:0]  = r.address;
    d[37:22] = r.length;
    d[38]    = r.phys;
    d[39]    = r.rd;
    d[40]    = r.wr;
    d[44:41] = r.index;
    d[45]    = r.env;
    d[61:46] = r.laddr;
    d[83:62] = r.paddr;
    d[84]    = r.is_read;
    return d;
  endfunction

  // entered and left on a falling edge
  task automatic send_word(wp_req_t r, bit fixed, wp_result_t exp);
    wp_result_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_word(r);
    s_tuser  <= r.mode;
    do @(posedge clk); while (!s_tready);
    pred = watch_step(r);
    if (r.mode == wrt_pkg::MODE_CHECK && pred.ok) n_hits++;
    if (!pred.ok && r.mode != wrt_pkg::MODE_CHECK && r.mode != wrt_pkg::MODE_FIND) n_rejects++;
    exp_fifo[exp_wr % EXP_DEPTH] = fixed ? exp : pred;
    exp_wr++;
    n_words++;
    @(negedge clk);
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        // long hold-off so the block backs up into its input
        stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL - 1) @(negedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    wp_result_t got;
    wp_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.ok  = m_tdata[0];
      got.hit = m_tdata[4:1];
      got.cnt = m_tdata[8:5];
      got.act = m_tdata[9];
      if (exp_wr == exp_rd) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result word %h", m_tdata);
      end else begin
        want = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        n_results++;
        if (got.ok !== want.ok || got.hit !== want.hit || got.cnt !== want.cnt ||
            got.act !== want.act) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display({"result %0d: expected ok %b hit %0d count %0d active %b,",
                      " got ok %b hit %0d count %0d active %b"},
                     n_results, want.ok, want.hit, want.cnt, want.act,
                     got.ok, got.hit, got.cnt, got.act);
        end
      end
    end
  end

  initial begin
    wp_result_t none;
    int i;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    errors    = 0;
    n_words   = 0;
    n_results = 0;
    n_hits    = 0;
    n_rejects = 0;
    calm      = 1'b0;
    stall_req = 1'b0;
    wp_count  = 0;
    wp_active = 1'b0;
    exp_wr    = 0;
    exp_rd    = 0;
    n_rows    = 0;
    none      = '{ok: 1'b0, hit: '0, cnt: '0, act: 1'b0};

    // empty table: everything refused, check gated off; then three adds and range checks
    add_row(fixed_row(w_check(16'h0000, 22'h000000, 1'b1), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_idx(wrt_pkg::MODE_REMOVE, 4'd0, 1'b0), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_idx(wrt_pkg::MODE_SET_EN, 4'd15, 1'b1), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_find(22'h000000, 1'b0), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_add(22'h000040, 16'h0000, 1'b0, 1'b1, 1'b1), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_add(22'h000040, 16'h0005, 1'b0, 1'b0, 1'b0), 1'b0, 0, 1'b0));
    add_row(fixed_row(blank_req(MODE_SPARE_LO), 1'b0, 0, 1'b0));
    add_row(fixed_row(w_add(22'h000100, 16'h0010, 1'b0, 1'b1, 1'b0), 1'b1, 1, 1'b1));
    add_row(fixed_row(w_add(22'h3FFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1), 1'b1, 2, 1'b1));
    add_row(fixed_row(w_add(22'h000000, 16'hFFFF, 1'b0, 1'b0, 1'b1), 1'b1, 3, 1'b1));
    add_row(pred_row(w_check(16'h0100, 22'h000000, 1'b1)));
    add_row(pred_row(w_check(16'hFFFF, 22'h3FFFFF, 1'b1)));
    add_row(pred_row(w_check(16'hFFFE, 22'h000000, 1'b0)));
    // find still sees a disabled entry
    add_row(pred_row(w_idx(wrt_pkg::MODE_SET_EN, 4'd1, 1'b0)));
    add_row(pred_row(w_find(22'h3FFFFF, 1'b1)));
    add_row(pred_row(w_idx(wrt_pkg::MODE_SET_EN, 4'd1, 1'b1)));
    add_row(pred_row(w_idx(wrt_pkg::MODE_REMOVE, 4'd0, 1'b0)));
    for (i = 0; i < DEPTH - 2; i++)
      add_row(pred_row(w_add(ADDR_W'(22'h001000 * (i + 1)), LEN_W'(16'h0100 + i),
                             1'(i), 1'b1, 1'(i >> 1))));
    add_row(fixed_row(w_add(22'h002000, 16'h0010, 1'b0, 1'b1, 1'b1), 1'b0, DEPTH, 1'b1));
    add_row(pred_row(blank_req(MODE_SPARE_HI)));
    add_row(fixed_row(blank_req(wrt_pkg::MODE_CLEAR), 1'b1, 0, 1'b0));
    add_row(fixed_row(w_check(16'h0100, 22'h3FFFFF, 1'b1), 1'b0, 0, 1'b0));

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < n_rows; i++) send_word(rows[i].req, rows[i].fixed, rows[i].exp);

    for (i = 0; i < N_RANDOM; i++) begin
      if (i == STALL_AT) stall_req = 1'b1;
      if (i == N_RANDOM - N_CALM) calm = 1'b1;
      send_word(rand_req(), 1'b0, none);
    end
    s_tvalid <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operation words sent, %0d result words checked, %0d errors",
             n_words, n_results, errors);
    $display("%0d access checks hit a range, %0d operations refused", n_hits, n_rejects);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/wrt_pkg.sv
hdl/wrt_cell.sv
hdl/watchpoint_range_table.sv
bench/tb.sv
